// File: sv/crc8fb_pkg.sv
// Package for the CRC-8 frame builder: item and configuration types,
// frame byte positions, register indexes and the CRC-8 byte update.
// No dependencies.
`default_nettype none

package crc8fb_pkg;

    // Frame geometry.
    localparam int unsigned FRAME_LEN = 12;
    localparam int unsigned POS_W     = 4;

    typedef logic [POS_W-1:0] t_pos;

    // Byte positions inside one frame, in transmission order.
    localparam t_pos POS_START0 = 4'd0;
    localparam t_pos POS_START1 = 4'd1;
    localparam t_pos POS_DEVICE = 4'd2;
    localparam t_pos POS_CMD    = 4'd3;
    localparam t_pos POS_WORD0  = 4'd4;
    localparam t_pos POS_WORD1  = 4'd5;
    localparam t_pos POS_WORD2  = 4'd6;
    localparam t_pos POS_WORD3  = 4'd7;
    localparam t_pos POS_BYTE   = 4'd8;
    localparam t_pos POS_CRC    = 4'd9;
    localparam t_pos POS_STOP0  = 4'd10;
    localparam t_pos POS_STOP1  = 4'd11;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_START_FIRST  = 3'd0;
    localparam t_cfg_idx REG_START_SECOND = 3'd1;
    localparam t_cfg_idx REG_STOP_FIRST   = 3'd2;
    localparam t_cfg_idx REG_STOP_SECOND  = 3'd3;
    localparam t_cfg_idx REG_DEVICE_IDENT = 3'd4;
    localparam t_cfg_idx REG_CRC_POLY     = 3'd5;
    localparam t_cfg_idx REG_CRC_INIT     = 3'd6;

    localparam logic [7:0] CRC_POLY_RESET = 8'h07;
    localparam logic [7:0] CRC_MSB_MASK   = 8'h80;

    // One input word as it sits in the queue.
    typedef struct packed {
        logic [7:0]        command_id;
        logic [31:0]       payload_word;
        logic signed [7:0] payload_byte;
    } t_item;

    // Configuration seen by the frame serializer.
    typedef struct packed {
        logic [7:0] start_first;
        logic [7:0] start_second;
        logic [7:0] stop_first;
        logic [7:0] stop_second;
        logic [7:0] device_ident;
        logic [7:0] crc_poly;
        logic [7:0] crc_init;
    } t_cfg;

    // MSB-first CRC-8 update over one byte.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] acc;
        acc = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if ((acc & CRC_MSB_MASK) != 8'h00) begin
                acc = {acc[6:0], 1'b0} ^ poly;
            end else begin
                acc = {acc[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// File: sv/crc8fb_queue.sv
// Front part of the CRC-8 frame builder: accepts input words into a
// short queue. Depends on crc8fb_pkg.
`default_nettype none

module crc8fb_queue
    import crc8fb_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_head_valid,
    output t_item      o_head,
    input  wire logic  i_pop
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          push;
    logic          pop;

    assign o_ready      = (r_count != FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign push         = i_valid && o_ready;
    assign pop          = i_pop && o_head_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage for queued words.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/crc8fb_serializer.sv
// Back part of the CRC-8 frame builder: turns the queue head into twelve
// frame bytes with a running CRC-8. Depends on crc8fb_pkg.
`default_nettype none

module crc8fb_serializer
    import crc8fb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_head_valid,
    input  wire t_item i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [7:0] o_frame_byte,
    output logic       o_last_of_frame
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_crc, n_crc;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             load;
    logic [7:0]       cur_byte;
    logic [7:0]       crc_base;

    // Output register takes a new word when empty or being drained.
    assign load  = i_head_valid && (!r_valid || i_ready);
    assign o_pop = load && (r_pos == POS_STOP1);

    // Select the byte for the current frame position.
    always_comb begin
        unique case (r_pos)
            POS_START0: cur_byte = i_cfg.start_first;
            POS_START1: cur_byte = i_cfg.start_second;
            POS_DEVICE: cur_byte = i_cfg.device_ident;
            POS_CMD:    cur_byte = i_head.command_id;
            POS_WORD0:  cur_byte = i_head.payload_word[7:0];
            POS_WORD1:  cur_byte = i_head.payload_word[15:8];
            POS_WORD2:  cur_byte = i_head.payload_word[23:16];
            POS_WORD3:  cur_byte = i_head.payload_word[31:24];
            POS_BYTE:   cur_byte = i_head.payload_byte;
            POS_CRC:    cur_byte = r_crc;
            POS_STOP0:  cur_byte = i_cfg.stop_first;
            POS_STOP1:  cur_byte = i_cfg.stop_second;
            default:    cur_byte = 8'h00;
        endcase
    end

    // Running CRC over the first nine bytes; restart at the first byte.
    assign crc_base = (r_pos == POS_START0) ? i_cfg.crc_init : r_crc;

    always_comb begin
        n_crc = r_crc;
        n_pos = r_pos;
        if (load) begin
            if (r_pos < POS_CRC) begin
                n_crc = crc8_step(crc_base, cur_byte, i_cfg.crc_poly);
            end
            n_pos = (r_pos == POS_STOP1) ? POS_START0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_START0;
            r_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload registers: CRC accumulator and output word.
    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        if (load) begin
            r_byte <= cur_byte;
            r_last <= (r_pos == POS_STOP1);
        end
    end

    assign o_valid         = r_valid;
    assign o_frame_byte    = r_byte;
    assign o_last_of_frame = r_last;

endmodule

`default_nettype wire

// File: sv/crc8_frame_builder.sv
// CRC-8 frame builder: each input word becomes a 12-byte frame, one byte per output word.
// The first frame byte passes through the input queue and then the serializer output register.
// Throughput: one frame byte per cycle while i_out_ready is high, set by the
// byte-wide serializer output register; frames follow without gaps if words are queued.
// Reset: synchronous, active low; empties the queue and serializer, resets the config.
// Depends on crc8fb_pkg, crc8fb_queue and crc8fb_serializer.
`default_nettype none

module crc8_frame_builder
    import crc8fb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    // Input channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_command_id,
    input  wire logic [31:0]          i_payload_word,
    input  wire logic signed [7:0]    i_payload_byte,
    // Output channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [7:0]                o_frame_byte,
    output logic                      o_last_of_frame
);

    t_cfg  r_cfg;
    t_item in_item;
    t_item head;
    logic  head_valid;
    logic  pop;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{crc_poly: CRC_POLY_RESET, default: 8'h00};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START_FIRST:  r_cfg.start_first  <= i_cfg_data;
                REG_START_SECOND: r_cfg.start_second <= i_cfg_data;
                REG_STOP_FIRST:   r_cfg.stop_first   <= i_cfg_data;
                REG_STOP_SECOND:  r_cfg.stop_second  <= i_cfg_data;
                REG_DEVICE_IDENT: r_cfg.device_ident <= i_cfg_data;
                REG_CRC_POLY:     r_cfg.crc_poly     <= i_cfg_data;
                REG_CRC_INIT:     r_cfg.crc_init     <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign in_item.command_id   = i_command_id;
    assign in_item.payload_word = i_payload_word;
    assign in_item.payload_byte = i_payload_byte;

    // Front: input queue.
    crc8fb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (in_item),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Back: frame serializer with CRC.
    crc8fb_serializer u_serializer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_frame_byte    (o_frame_byte),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

`default_nettype wire
